FILE: rtl/gss_pkg.sv
// Shared types and constants for the Gouraud span setup block.
`timescale 1ns / 1ps
`default_nettype none
package gss_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 10;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int XqBits      = CoordBits + 16;
  localparam int SpanLimit   = 8;
  localparam int QueueDepth  = 2;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [CoordBits-1:0] vertex_x;
    logic [CoordBits-1:0] vertex_y;
    logic [7:0]           vertex_red;
    logic [7:0]           vertex_green;
    logic [7:0]           vertex_blue;
    logic                 first_vertex;
    logic [CoordBits-1:0] scan_line;
  } gss_in_t;

  typedef struct packed {
    logic [XqBits-1:0]    span_begin_x;
    logic [XqBits-1:0]    span_end_x;
    logic [15:0]          left_red;
    logic [15:0]          left_green;
    logic [15:0]          left_blue;
    logic [15:0]          right_red;
    logic [15:0]          right_green;
    logic [15:0]          right_blue;
    logic [CoordBits-1:0] out_line;
    logic                 last_span;
  } gss_out_t;

  // Query handed from front to back: snapshot of the vertex count and line.
  typedef struct packed {
    logic [CntBits-1:0]   count;
    logic [CoordBits-1:0] line;
  } gss_query_t;

endpackage
`default_nettype wire

FILE: rtl/gss_front.sv
// Front end: accepts vertex loads and counts them, queries pushed onto a short queue.
`timescale 1ns / 1ps
`default_nettype none
module gss_front
  import gss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire gss_in_t      req,
  input  wire logic         req_valid,
  output logic              req_ready,
  output gss_query_t        q_data,
  output logic              q_valid,
  input  wire logic         q_pop,
  input  wire logic         back_busy,
  output logic              store_idle
);

  gss_query_t           queue [QueueDepth];
  logic [1:0]           fill;
  logic                 wr_ptr, rd_ptr;
  logic [CntBits-1:0]   vertex_count;
  logic                 take, push, load;

  // Loads stall while a query is queued or running so it sees a stable store.
  assign store_idle = (fill == 2'd0) && !back_busy;
  assign req_ready  = (req.action == ActQuery) ? (fill != 2'(QueueDepth)) : store_idle;
  assign take = req_valid && req_ready;
  assign push = take && (req.action == ActQuery);
  assign load = take && (req.action == ActLoad);
  assign q_valid = (fill != 2'd0);
  assign q_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0; vertex_count <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= '{count: vertex_count, line: req.scan_line};
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
      if (load) begin
        if (req.first_vertex) vertex_count <= CntBits'(1);
        else if (vertex_count != CntBits'(MaxVertices)) vertex_count <= vertex_count + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'(QueueDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CntBits'(MaxVertices)) else $error("count overrun");
`endif

endmodule
`default_nettype wire

FILE: rtl/gss_divider.sv
// Restoring divider for unsigned quotient with round-half-up, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module gss_divider
  import gss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [XqBits+CoordBits:0] num,   // 2*|n| + d (2*|n| - d for negative n)
  input  wire logic [CoordBits:0]   den,        // 2*d
  output logic                      done,
  output logic [XqBits+CoordBits:0] quo,
  output logic                      exact
);

  localparam int NW = XqBits + CoordBits + 1;
  localparam int SW = $clog2(NW + 1);

  logic [NW-1:0]      q;
  logic [CoordBits+1:0] rem;
  logic [SW-1:0]      steps;
  logic               busy;
  logic [CoordBits+1:0] trial;

  assign trial = {rem[CoordBits:0], q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= busy && !start && (steps == SW'(1));
      if (start) begin
        busy <= 1'b1; q <= num; rem <= '0; steps <= SW'(NW);
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den}; q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial; q <= {q[NW-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == SW'(1)) busy <= 1'b0;
      end
    end
  end

  assign quo   = q;
  assign exact = (rem == '0);

endmodule
`default_nettype wire

FILE: rtl/gss_back.sv
// Back end: edge walk, crossing/colour evaluation, insertion sort, span output.
`timescale 1ns / 1ps
`default_nettype none
module gss_back
  import gss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire gss_in_t      load_req,
  input  wire logic         load_we,
  input  wire logic [CntBits-1:0] load_cnt,
  input  wire gss_query_t   q_data,
  input  wire logic         q_valid,
  output logic              q_pop,
  output logic              busy,
  output gss_out_t          rsp,
  output logic              rsp_valid,
  input  wire logic         rsp_ready
);

  localparam int NW = XqBits + CoordBits + 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_EDGE = 4'd2, S_DIV = 4'd3,
                         S_WAIT = 4'd4, S_NEXT = 4'd5, S_CMP = 4'd6, S_EMIT = 4'd7,
                         S_SORT = 4'd8, S_START = 4'd9;

  typedef struct packed {
    logic [XqBits-1:0]    x;
    logic signed [CoordBits:0] dx;
    logic [CoordBits-1:0] dy;
    logic [CoordBits-1:0] ymin;
    logic [IdxBits-1:0]   idx;
    logic [15:0]          r, g, b;
  } edge_t;

  logic [CoordBits-1:0] mem_x [MaxVertices];
  logic [CoordBits-1:0] mem_y [MaxVertices];
  logic [23:0]          mem_c [MaxVertices];

  logic [3:0]           state;
  gss_query_t           qry;
  logic [IdxBits:0]     i;
  logic [IdxBits-1:0]   ra, rb;
  logic [CoordBits-1:0] xa, ya, xb, yb;
  logic [23:0]          ca, cb;
  edge_t                e;
  edge_t                tbl [MaxVertices];
  logic [IdxBits:0]     n, k;
  logic [1:0]           term;        // 0: x, 1..3: colours
  logic [CoordBits-1:0] t;
  logic                 neg;
  logic signed [NW-1:0] prod;
  logic                 dstart, ddone, dexact;
  logic [NW-1:0]        dnum, dquo;
  logic [3:0]           spans, sk;
  logic [IdxBits-1:0]   last_idx;
  logic signed [2*CoordBits+2:0] l_s, r_s;
  logic                 is_left;

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_x[IdxBits'(load_cnt)] <= load_req.vertex_x;
      mem_y[IdxBits'(load_cnt)] <= load_req.vertex_y;
      mem_c[IdxBits'(load_cnt)] <= {load_req.vertex_red, load_req.vertex_green,
                                    load_req.vertex_blue};
    end
    xa <= mem_x[ra]; ya <= mem_y[ra]; ca <= mem_c[ra];
    xb <= mem_x[rb]; yb <= mem_y[rb]; cb <= mem_c[rb];
  end

  assign last_idx = IdxBits'(qry.count - 1'b1);
  assign ra = IdxBits'(i);
  assign rb = (IdxBits'(i) == last_idx) ? '0 : IdxBits'(i) + 1'b1;

  gss_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum),
    .den({e.dy, 1'b0}), .done(ddone), .quo(dquo), .exact(dexact)
  );

  // Multiplicand for current term: dx or (ch-cl), then times t and scaled by 65536 or 256.
  logic signed [CoordBits+1:0] delta;
  logic [7:0] cl_s, ch_s;
  always_comb begin
    cl_s = 8'd0; ch_s = 8'd0;
    case (term)
      2'd1: begin cl_s = (ya < yb) ? ca[23:16] : cb[23:16];
                  ch_s = (ya < yb) ? cb[23:16] : ca[23:16]; end
      2'd2: begin cl_s = (ya < yb) ? ca[15:8] : cb[15:8];
                  ch_s = (ya < yb) ? cb[15:8] : ca[15:8]; end
      default: begin cl_s = (ya < yb) ? ca[7:0] : cb[7:0];
                  ch_s = (ya < yb) ? cb[7:0] : ca[7:0]; end
    endcase
    if (term == 2'd0) delta = (CoordBits+2)'(e.dx);
    else delta = (CoordBits+2)'($signed({1'b0, ch_s}) - $signed({1'b0, cl_s}));
  end

  // Signed rounded quotient from unsigned |n| divide: floor((2n+d)/(2d)).
  // Negative n divides 2|n|-d and rounds the magnitude up.
  logic [NW-1:0] mag;
  logic signed [NW+1:0] qv;
  always_comb begin
    mag = prod[NW-1] ? NW'(-prod) : NW'(prod);
    if (neg) qv = -$signed({2'b0, dquo}) - $signed({{(NW+1){1'b0}}, !dexact});
    else qv = $signed({2'b0, dquo});
  end

  // Comparison with the table entry just before the insertion point (the tail at first).
  edge_t tk;
  assign tk = tbl[IdxBits'(k - 1'b1)];
  always_comb begin
    l_s = e.dx * $signed({1'b0, tk.dy});
    r_s = tk.dx * $signed({1'b0, e.dy});
    if (e.x != tk.x) is_left = e.x < tk.x;
    else if (l_s != r_s) is_left = l_s < r_s;
    else if (e.ymin != tk.ymin) is_left = e.ymin < tk.ymin;
    else is_left = e.idx < tk.idx;
  end

  logic signed [NW+2:0] val;
  logic [XqBits-1:0] xres;
  logic [15:0] cres;
  always_comb begin
    xres = '0; cres = '0;
    val = qv;
    if (term == 2'd0) begin
      val = val + $signed((NW+3)'(e.x));
      xres = (val < 0) ? '0 : (val > $signed((NW+3)'((1 << XqBits) - 1))) ?
             XqBits'((1 << XqBits) - 1) : XqBits'(val);
    end else begin
      val = val + $signed((NW+3)'({cl_s, 8'd0}));
      cres = (val < 0) ? 16'd0 : (val > 65535) ? 16'hFFFF : 16'(val);
    end
  end

  assign busy  = (state != S_IDLE);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign rsp_valid = (state == S_EMIT);

  always_comb begin
    rsp.span_begin_x = tbl[IdxBits'({sk, 1'b0})].x;
    rsp.span_end_x   = tbl[IdxBits'({sk, 1'b1})].x;
    rsp.left_red  = tbl[0].r; rsp.left_green  = tbl[0].g; rsp.left_blue  = tbl[0].b;
    rsp.right_red = tbl[1].r; rsp.right_green = tbl[1].g; rsp.right_blue = tbl[1].b;
    rsp.out_line  = qry.line;
    rsp.last_span = (sk == spans - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; dstart <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          qry <= q_data; i <= '0; n <= '0; state <= S_RD;
        end
        S_RD: state <= (i >= (IdxBits+1)'(qry.count)) ? S_SORT : S_EDGE;
        S_EDGE: begin
          if (ya == yb || qry.line < ((ya < yb) ? ya : yb) ||
              qry.line >= ((ya < yb) ? yb : ya)) begin
            state <= S_NEXT;
          end else begin
            e.dy   <= (ya < yb) ? yb - ya : ya - yb;
            e.dx   <= (ya < yb) ? $signed({1'b0, xb}) - $signed({1'b0, xa})
                                : $signed({1'b0, xa}) - $signed({1'b0, xb});
            e.ymin <= (ya < yb) ? ya : yb;
            e.idx  <= IdxBits'(i);
            e.x    <= XqBits'({(ya < yb) ? xa : xb, 16'd0});
            t      <= qry.line - ((ya < yb) ? ya : yb);
            term   <= 2'd0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          prod  <= NW'(delta * $signed({1'b0, t})) <<< ((term == 2'd0) ? 16 : 8);
          state <= S_START;
        end
        S_START: begin
          neg <= prod[NW-1];
          // 2|n| + d, or 2|n| - d for negative n (zero when that drops below zero)
          if (!prod[NW-1]) dnum <= (mag << 1) + NW'(e.dy);
          else if ((mag << 1) > NW'(e.dy)) dnum <= (mag << 1) - NW'(e.dy);
          else dnum <= '0;
          dstart <= 1'b1;
          state  <= S_WAIT;
        end
        S_WAIT: begin
          dstart <= 1'b0;
          if (ddone) begin
            case (term)
              2'd0: e.x <= xres;
              2'd1: e.r <= cres;
              2'd2: e.g <= cres;
              default: e.b <= cres;
            endcase
            if (term == 2'd3) begin k <= n; state <= S_CMP; end
            else begin term <= term + 1'b1; state <= S_DIV; end
          end
        end
        S_CMP: begin
          if (k != '0 && is_left) begin
            tbl[IdxBits'(k)] <= tk; k <= k - 1'b1;
          end else begin
            tbl[IdxBits'(k)] <= e; n <= n + 1'b1; state <= S_NEXT;
          end
        end
        S_NEXT: begin i <= i + 1'b1; state <= S_RD; end
        S_SORT: begin
          sk <= '0;
          spans <= (n[IdxBits:1] > SpanLimit) ? 4'(SpanLimit) : 4'(n[IdxBits:1]);
          state <= (n < 2) ? S_IDLE : S_EMIT;
        end
        S_EMIT: if (rsp_ready) begin
          if (sk == spans - 1'b1) state <= S_IDLE;
          sk <= sk + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_emit_has_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> n >= 2) else $error("span without pair");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_RD) else $error("pop not started");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(sk)) else $error("span dropped");
`endif

endmodule
`default_nettype wire

FILE: rtl/gouraud_scanline_span_setup_unit.sv
// Top level of the Gouraud scanline span setup block.
//   channel | dir | payload   | handshake
//   req     | in  | gss_in_t  | req_valid / req_ready
//   rsp     | out | gss_out_t | rsp_valid / rsp_ready
// A load is accepted once no query is queued or running; each active edge of a query
// runs four divides (x and three colours) in the 37-step bit-serial divider, and the
// sorted edges then go out as spans.
// Up to two queries wait in the queue while the back end works.
// Reset clears the vertex count, queue and controller; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gouraud_scanline_span_setup_unit
  import gss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire gss_in_t  req,
  input  wire logic     req_valid,
  output logic          req_ready,
  output gss_out_t      rsp,
  output logic          rsp_valid,
  input  wire logic     rsp_ready
);

  gss_query_t          q_data;
  logic                q_valid, q_pop, back_busy, store_idle, load_we;
  logic [CntBits-1:0]  wr_cnt;

  gss_front u_front (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_ready(req_ready),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .back_busy(back_busy),
    .store_idle(store_idle)
  );

  // Store write address mirrors the front count, tracked here.
  logic [CntBits-1:0] cnt;
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (load_we) cnt <= wr_cnt + 1'b1;
  end
  assign wr_cnt  = req.first_vertex ? '0 : cnt;
  assign load_we = req_valid && store_idle && (req.action == ActLoad) &&
                   (wr_cnt != CntBits'(MaxVertices));

  gss_back u_back (
    .clk(clk), .rst(rst), .load_req(req), .load_we(load_we), .load_cnt(wr_cnt),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .busy(back_busy),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
  );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the Gouraud scanline span setup block.
`timescale 1ns / 1ps
module tb_top;
  import gss_pkg::*;

  localparam int CycleLimit = 10000000;

  typedef struct {
    longint xq;
    longint dx;
    longint dy;
    longint ymin;
    int     idx;
    longint col[3];
  } edge_rec_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  gss_in_t  req = '0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  gss_out_t rsp;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;

  gouraud_scanline_span_setup_unit dut (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_ready(req_ready),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
  );

  always #5 clk = ~clk;

  // Predictor state: shadow vertex store
  logic [CoordBits-1:0] vx_mem [MaxVertices];
  logic [CoordBits-1:0] vy_mem [MaxVertices];
  logic [23:0]          vc_mem [MaxVertices];
  int                   vcount = 0;

  gss_in_t  pending_reqs[$];
  gss_out_t expected_spans[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       stim_done = 1'b0;
  bit       hold_off = 1'b0;

  function automatic longint fdiv(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint rdiv(longint num, longint den);
    return fdiv(2 * num + den, 2 * den);
  endfunction

  function automatic longint clampv(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit edge_left_of(edge_rec_t a, edge_rec_t b);
    longint l, r;
    if (a.xq != b.xq) return a.xq < b.xq;
    l = a.dx * b.dy;
    r = b.dx * a.dy;
    if (l != r) return l < r;
    if (a.ymin != b.ymin) return a.ymin < b.ymin;
    return a.idx < b.idx;
  endfunction

  task automatic predict_spans(input gss_in_t r);
    edge_rec_t act[$];
    edge_rec_t e;
    int j, lo, hi, k, nspan;
    longint y, t, cl, ch;
    gss_out_t s;
    if (r.action == ActLoad) begin
      if (r.first_vertex) vcount = 0;
      if (vcount < MaxVertices) begin
        vx_mem[vcount] = r.vertex_x;
        vy_mem[vcount] = r.vertex_y;
        vc_mem[vcount] = {r.vertex_red, r.vertex_green, r.vertex_blue};
        vcount++;
      end
      return;
    end
    y = longint'(r.scan_line);
    for (int i = 0; i < vcount; i++) begin
      j = (i + 1 == vcount) ? 0 : i + 1;
      if (vy_mem[i] == vy_mem[j]) continue;
      if (vy_mem[i] < vy_mem[j]) begin lo = i; hi = j; end
      else begin lo = j; hi = i; end
      if (y < longint'(vy_mem[lo]) || y >= longint'(vy_mem[hi])) continue;
      t = y - longint'(vy_mem[lo]);
      e.dy = longint'(vy_mem[hi]) - longint'(vy_mem[lo]);
      e.dx = longint'(vx_mem[hi]) - longint'(vx_mem[lo]);
      e.ymin = longint'(vy_mem[lo]);
      e.idx = i;
      e.xq = clampv(longint'(vx_mem[lo]) * 65536 + rdiv(e.dx * t * 65536, e.dy),
                    (longint'(1) << XqBits) - 1);
      for (int c = 0; c < 3; c++) begin
        cl = longint'((vc_mem[lo] >> (16 - 8 * c)) & 24'hFF);
        ch = longint'((vc_mem[hi] >> (16 - 8 * c)) & 24'hFF);
        e.col[c] = clampv(cl * 256 + rdiv((ch - cl) * 256 * t, e.dy), 65535);
      end
      k = act.size();
      while (k > 0 && edge_left_of(e, act[k-1])) k--;
      act.insert(k, e);
    end
    if (act.size() < 2) return;
    nspan = act.size() / 2;
    if (nspan > SpanLimit) nspan = SpanLimit;
    for (int q = 0; q < nspan; q++) begin
      s.span_begin_x = XqBits'(act[2*q].xq);
      s.span_end_x   = XqBits'(act[2*q+1].xq);
      s.left_red     = 16'(act[0].col[0]);
      s.left_green   = 16'(act[0].col[1]);
      s.left_blue    = 16'(act[0].col[2]);
      s.right_red    = 16'(act[1].col[0]);
      s.right_green  = 16'(act[1].col[1]);
      s.right_blue   = 16'(act[1].col[2]);
      s.out_line     = r.scan_line;
      s.last_span    = (q == nspan - 1);
      expected_spans.push_back(s);
    end
  endtask

  // Driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) predict_spans(req);
      if (req_valid && !req_ready) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    if (rst || hold_off) rsp_ready <= 1'b0;
    else if (stall_mode == 0) rsp_ready <= 1'b1;
    else if (stall_mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
    else rsp_ready <= ($urandom_range(0, 3) == 0);
  end

  int hold_cnt = 0;
  always @(posedge clk) begin
    if (cycles == 20000) begin
      hold_off <= 1'b1;
      hold_cnt <= 30000;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin
    gss_out_t want;
    cycles <= cycles + 1;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span: %p", rsp);
      end else begin
        want = expected_spans.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("span mismatch: exp %p got %p", want, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic gss_in_t make_load(int x, int y, bit first);
    gss_in_t r;
    r = '0;
    r.action = ActLoad;
    r.vertex_x = CoordBits'(x);
    r.vertex_y = CoordBits'(y);
    r.vertex_red = 8'($urandom);
    r.vertex_green = 8'($urandom);
    r.vertex_blue = 8'($urandom);
    r.first_vertex = first;
    r.scan_line = CoordBits'($urandom);
    return r;
  endfunction

  function automatic gss_in_t make_query(int line, bit fv);
    gss_in_t r;
    r = '0;
    r.action = ActQuery;
    r.vertex_x = CoordBits'($urandom);
    r.vertex_y = CoordBits'($urandom);
    r.vertex_red = 8'($urandom);
    r.vertex_green = 8'($urandom);
    r.vertex_blue = 8'($urandom);
    r.first_vertex = fv;
    r.scan_line = CoordBits'(line);
    return r;
  endfunction

  initial begin
    int nv, ymin, ymax, added;
    gss_in_t r;
    // Directed: extreme triangle, full colors
    r = make_load(0, 0, 1'b1);
    r.vertex_red = 8'hFF; r.vertex_green = 8'h00; r.vertex_blue = 8'hFF;
    pending_reqs.push_back(r);
    r = make_load(1023, 1023, 1'b0);
    r.vertex_red = 8'h00; r.vertex_green = 8'hFF; r.vertex_blue = 8'h00;
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_load(0, 1023, 1'b0));
    pending_reqs.push_back(make_query(0, 1'b0));
    pending_reqs.push_back(make_query(511, 1'b1));
    pending_reqs.push_back(make_query(1022, 1'b0));
    pending_reqs.push_back(make_query(1023, 1'b0));
    // one vertex, then two coincident edges
    pending_reqs.push_back(make_load(5, 10, 1'b1));
    pending_reqs.push_back(make_query(10, 1'b0));
    pending_reqs.push_back(make_load(900, 20, 1'b0));
    pending_reqs.push_back(make_query(15, 1'b0));
    // zigzag of 16 vertices: many spans, then store full ignore
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(make_load(i * 60, (i % 2) ? 100 : 0, i == 0));
    pending_reqs.push_back(make_load(7, 7, 1'b0));
    pending_reqs.push_back(make_query(50, 1'b0));
    // random polygons
    added = 0;
    while (added < 430) begin
      nv = $urandom_range(0, 7) == 0 ? $urandom_range(1, 17) : $urandom_range(3, 8);
      ymin = 1023; ymax = 0;
      for (int i = 0; i < nv; i++) begin
        int yy;
        yy = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 1023 : 0)
                                         : $urandom_range(0, 1023);
        if (yy < ymin) ymin = yy;
        if (yy > ymax) ymax = yy;
        pending_reqs.push_back(make_load($urandom_range(0, 1023), yy,
                                         i == 0 || $urandom_range(0, 30) == 0));
        added++;
      end
      for (int q = $urandom_range(1, 5); q > 0; q--) begin
        pending_reqs.push_back(make_query($urandom_range(0, 6) == 0 ? $urandom_range(0, 1023)
                                          : $urandom_range(ymin, ymax),
                                          1'($urandom_range(0, 1))));
        added++;
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_spans.size() == 0);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && expected_spans.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
